[rtl/pfkp_pkg.sv]
// Shared types and constants for the packet flow key parser.
package pfkp_pkg;

  localparam logic [15:0] EtherTypeLldp = 16'h88CC;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [7:0] IcmpEchoRequest = 8'd8;
  localparam logic [7:0] IcmpEchoReply   = 8'd0;

  localparam logic [31:0] PeerAReset  = 32'hC0A83203;
  localparam logic [31:0] PeerBReset  = 32'hC0A83204;
  localparam logic [31:0] ExemptReset = 32'hC0A8331E;

  localparam int unsigned PosEtherHi  = 12;
  localparam int unsigned PosEtherLo  = 13;
  localparam int unsigned PosIhl      = 14;
  localparam int unsigned PosProto    = 23;
  localparam int unsigned PosSrcFirst = 26;
  localparam int unsigned PosSrcLast  = 29;
  localparam int unsigned PosDstFirst = 30;
  localparam int unsigned PosDstLast  = 33;
  localparam int unsigned PosL4Min    = 34;
  localparam int unsigned EthHdrLen   = 14;
  localparam int unsigned MinIpFrame  = 34;
  localparam int unsigned MinIhl      = 5;
  localparam int unsigned IcmpNeed    = 8;
  localparam int unsigned TcpNeed     = 20;
  localparam int unsigned UdpNeed     = 8;
  localparam int unsigned L4WordBytes = 4;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    VerdictParsed    = 2'd0,
    VerdictWhitelist = 2'd1,
    VerdictLldp      = 2'd2,
    VerdictBad       = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CfgPeerA  = 2'd0,
    CfgPeerB  = 2'd1,
    CfgExempt = 2'd2
  } cfg_reg_e;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [15:0] frame_length;
  } key_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [31:0] transport_word;
    logic [6:0]  transport_start;
  } hdr_t;

endpackage

[rtl/pfkp_stream_if.sv]
// Valid/ready stream interface carrying one request per handshake.
interface pfkp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/pfkp_front.sv]
// Front end: counts frame bytes and captures header fields, pushing a summary per frame.
module pfkp_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pfkp_pkg::frame_t       in_data_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic [LENGTH_BITS-1:0] push_len_o,
  output pfkp_pkg::hdr_t         push_hdr_o
);
  import pfkp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0] pos_q, len_d;
  hdr_t                   hdr_q, hdr_d;
  logic                   accept;
  logic [LENGTH_BITS-1:0] ts_ext;
  logic [7:0]             b;

  assign b          = in_data_i.frame_byte;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ts_ext     = LENGTH_BITS'(hdr_q.transport_start);
  assign len_d      = (pos_q != LenMax) ? pos_q + 1'b1 : pos_q;

  always_comb begin
    hdr_d = hdr_q;
    if (pos_q == LENGTH_BITS'(PosEtherHi)) begin
      hdr_d.ether_type = {b, 8'h00};
    end else if (pos_q == LENGTH_BITS'(PosEtherLo)) begin
      hdr_d.ether_type[7:0] = b;
    end else if (pos_q == LENGTH_BITS'(PosIhl)) begin
      hdr_d.header_words    = b[3:0];
      hdr_d.transport_start = 7'(EthHdrLen) + {1'b0, b[3:0], 2'b00};
    end else if (pos_q == LENGTH_BITS'(PosProto)) begin
      hdr_d.ip_protocol = b;
    end else if (pos_q >= LENGTH_BITS'(PosSrcFirst) && pos_q <= LENGTH_BITS'(PosSrcLast)) begin
      hdr_d.source_address = {hdr_q.source_address[23:0], b};
    end else if (pos_q >= LENGTH_BITS'(PosDstFirst) && pos_q <= LENGTH_BITS'(PosDstLast)) begin
      hdr_d.destination_address = {hdr_q.destination_address[23:0], b};
    end
    if (hdr_q.header_words >= 4'(MinIhl) && pos_q >= LENGTH_BITS'(PosL4Min) &&
        pos_q >= ts_ext && pos_q < ts_ext + LENGTH_BITS'(L4WordBytes)) begin
      hdr_d.transport_word = {hdr_q.transport_word[23:0], b};
    end
  end

  assign push_o     = accept && in_data_i.end_of_frame;
  assign push_len_o = len_d;
  assign push_hdr_o = hdr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else if (accept) begin
      if (in_data_i.end_of_frame) begin
        pos_q <= '0;
        hdr_q <= '0;
      end else begin
        pos_q <= len_d;
        hdr_q <= hdr_d;
      end
    end
  end
endmodule

[rtl/pfkp_queue.sv]
// Small FIFO of frame summaries between the front end and the verdict stage.
module pfkp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrBits'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

[rtl/pfkp_back.sv]
// Verdict stage: holds the whitelist registers, judges a frame summary and registers the key.
module pfkp_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  pfkp_pkg::cfg_idx_t      cfg_idx_i,
  input  pfkp_pkg::cfg_data_t     cfg_wdata_i,
  input  logic                    q_empty_i,
  input  logic [LENGTH_BITS-1:0]  head_len_i,
  input  pfkp_pkg::hdr_t          head_hdr_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pfkp_pkg::key_t          out_data_o
);
  import pfkp_pkg::*;

  logic [31:0]            peer_a_q, peer_b_q, exempt_q;
  logic                   valid_q;
  key_t                   key_q, key_d;
  logic [LENGTH_BITS-1:0] len, ts_ext;
  logic [7:0]             icmp_type;
  logic                   white;

  assign len       = head_len_i;
  assign ts_ext    = LENGTH_BITS'(head_hdr_i.transport_start);
  assign icmp_type = head_hdr_i.transport_word[31:24];
  assign white =
    (head_hdr_i.source_address == peer_a_q && head_hdr_i.destination_address == peer_b_q &&
     icmp_type == IcmpEchoRequest) ||
    (head_hdr_i.source_address == peer_b_q && head_hdr_i.destination_address == peer_a_q &&
     icmp_type == IcmpEchoReply) ||
    head_hdr_i.source_address == exempt_q || head_hdr_i.destination_address == exempt_q;

  always_comb begin
    key_d              = '0;
    key_d.verdict      = VerdictParsed;
    key_d.frame_length = 16'(len);
    if (len < LENGTH_BITS'(EthHdrLen)) begin
      key_d.verdict = VerdictBad;
    end else if (head_hdr_i.ether_type == EtherTypeLldp) begin
      key_d.verdict = VerdictLldp;
    end else if (head_hdr_i.ether_type != EtherTypeIpv4) begin
      key_d.verdict = VerdictBad;
    end else if (len < LENGTH_BITS'(MinIpFrame)) begin
      key_d.verdict = VerdictBad;
    end else if (head_hdr_i.header_words < 4'(MinIhl)) begin
      key_d.verdict = VerdictBad;
    end else if (head_hdr_i.ip_protocol == ProtoIcmp) begin
      if (len < ts_ext + LENGTH_BITS'(IcmpNeed)) begin
        key_d.verdict = VerdictBad;
      end else if (white) begin
        key_d.verdict = VerdictWhitelist;
      end
    end else if (head_hdr_i.ip_protocol == ProtoTcp) begin
      if (len < ts_ext + LENGTH_BITS'(TcpNeed)) begin
        key_d.verdict = VerdictBad;
      end else begin
        key_d.l4_sport = head_hdr_i.transport_word[31:16];
        key_d.l4_dport = head_hdr_i.transport_word[15:0];
      end
    end else if (head_hdr_i.ip_protocol == ProtoUdp) begin
      if (len < ts_ext + LENGTH_BITS'(UdpNeed)) begin
        key_d.verdict = VerdictBad;
      end else begin
        key_d.l4_sport = head_hdr_i.transport_word[31:16];
        key_d.l4_dport = head_hdr_i.transport_word[15:0];
      end
    end
    if (key_d.verdict == VerdictParsed) begin
      key_d.src_addr = head_hdr_i.source_address;
      key_d.dst_addr = head_hdr_i.destination_address;
      key_d.protocol = head_hdr_i.ip_protocol;
    end else begin
      key_d.l4_sport = '0;
      key_d.l4_dport = '0;
    end
  end

  assign pop_o       = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_a_q <= PeerAReset;
      peer_b_q <= PeerBReset;
      exempt_q <= ExemptReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgPeerA) begin
        peer_a_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CfgPeerB) begin
        peer_b_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CfgExempt) begin
        exempt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_q <= key_d;
    end
  end
endmodule

[rtl/packet_flow_key_parser.sv]
// Top level of the Ethernet/IPv4 flow key parser.
//
//   Port     Dir  Request
//   frame_i  in   one frame byte with its end-of-frame mark
//   key_o    out  verdict, five-tuple key and frame length, one per frame
//   cfg_*    in   write of a whitelist address register
//
// One byte is taken every cycle while the two-entry summary queue has room.
// The summary of a frame is written into the queue as its last byte is taken,
// is popped when the verdict stage register is free or being emptied, and then
// sits in that register as the valid verdict.
// A stalled output fills the queue, and only then does the input stall.
// Reset clears the byte counter, the captured header and the queue, and loads
// the default whitelist addresses.
module packet_flow_key_parser #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfkp_stream_if.sink         frame_i,
  pfkp_stream_if.source       key_o,
  input  logic                cfg_we_i,
  input  pfkp_pkg::cfg_idx_t  cfg_idx_i,
  input  pfkp_pkg::cfg_data_t cfg_wdata_i
);
  import pfkp_pkg::*;

  localparam int unsigned EntryBits = LENGTH_BITS + $bits(hdr_t);

  logic                   q_full, q_empty, push, pop;
  logic [LENGTH_BITS-1:0] push_len, head_len;
  hdr_t                   push_hdr, head_hdr;
  logic [EntryBits-1:0]   head_entry;
  frame_t                 in_data;
  key_t                   out_data;

  assign in_data         = frame_i.payload;
  assign key_o.payload   = out_data;
  assign {head_len, head_hdr} = head_entry;

  pfkp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .in_data_i  (in_data),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_len_o (push_len),
    .push_hdr_o (push_hdr)
  );

  pfkp_queue #(
    .WIDTH(EntryBits),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_len, push_hdr}),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  pfkp_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .head_len_i  (head_len),
    .head_hdr_i  (head_hdr),
    .pop_o       (pop),
    .out_valid_o (key_o.valid),
    .out_ready_i (key_o.ready),
    .out_data_o  (out_data)
  );
endmodule

[rtl/pfkp_checker.sv]
// Port-level checks of the flow key parser, bound to its top level.
module pfkp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input pfkp_pkg::key_t out_key_i
);
  import pfkp_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output request dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_key_i))
    else $error("Output payload changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_key_i.verdict != VerdictParsed |->
      out_key_i.src_addr == '0 && out_key_i.dst_addr == '0 && out_key_i.protocol == '0)
    else $error("Flow key fields set on a frame that was not parsed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_key_i.l4_sport != '0 || out_key_i.l4_dport != '0) |->
      out_key_i.verdict == VerdictParsed &&
      (out_key_i.protocol == ProtoTcp || out_key_i.protocol == ProtoUdp))
    else $error("Ports reported for a frame without a TCP or UDP header.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_key_i.verdict == VerdictWhitelist |->
      out_key_i.l4_sport == '0 && out_key_i.l4_dport == '0)
    else $error("Whitelisted frame reported with ports.");
endmodule

bind packet_flow_key_parser pfkp_checker u_pfkp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (key_o.valid),
  .out_ready_i (key_o.ready),
  .out_key_i   (key_o.payload)
);

[tb/sv/tb_packet_flow_key_parser.sv]
`timescale 1ns / 1ps
// Self-checking testbench that streams frames through the flow key parser and checks each key.
module tb_packet_flow_key_parser;
  import pfkp_pkg::*;

  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned LenMax       = 65535;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned MaxPrinted   = 100;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_wdata;

  pfkp_stream_if #(.payload_t(frame_t)) frame_if ();
  pfkp_stream_if #(.payload_t(key_t))   key_if ();

  packet_flow_key_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_if),
    .key_o       (key_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  frame_t      pending_bytes[$];
  key_t        flow_keys_due[$];
  key_t        next_key;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  logic [31:0] wl_peer_a;
  logic [31:0] wl_peer_b;
  logic [31:0] wl_exempt;

  int unsigned cur_pos;
  logic [15:0] cur_etype;
  logic [3:0]  cur_ihl;
  logic [7:0]  cur_proto;
  logic [31:0] cur_src;
  logic [31:0] cur_dst;
  logic [31:0] cur_l4word;
  logic [6:0]  cur_l4start;

  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic void clear_frame();
    cur_pos     = 0;
    cur_etype   = '0;
    cur_ihl     = '0;
    cur_proto   = '0;
    cur_src     = '0;
    cur_dst     = '0;
    cur_l4word  = '0;
    cur_l4start = '0;
  endfunction

  // Consumes one frame byte; returns 1 with the expected key on the last byte.
  function automatic bit predict_byte(input frame_t item, output key_t want);
    logic [7:0]  b;
    logic [7:0]  icmp_type;
    int unsigned pos;
    int unsigned len;
    int unsigned need;
    bit          has_l4;
    b = item.frame_byte;
    pos = cur_pos;
    want = '0;
    if (pos == PosEtherHi) cur_etype = {b, 8'h00};
    else if (pos == PosEtherLo) cur_etype[7:0] = b;
    else if (pos == PosIhl) begin
      cur_ihl = b[3:0];
      cur_l4start = 7'(EthHdrLen + 4 * cur_ihl);
    end else if (pos == PosProto) cur_proto = b;
    else if (pos >= PosSrcFirst && pos <= PosSrcLast) cur_src = {cur_src[23:0], b};
    else if (pos >= PosDstFirst && pos <= PosDstLast) cur_dst = {cur_dst[23:0], b};
    if (cur_ihl >= MinIhl && pos >= PosL4Min && pos >= cur_l4start &&
        pos - cur_l4start < L4WordBytes) begin
      cur_l4word = {cur_l4word[23:0], b};
    end
    len = (pos < LenMax) ? pos + 1 : LenMax;
    if (!item.end_of_frame) begin
      cur_pos = len;
      return 1'b0;
    end
    want.frame_length = 16'(len);
    if (len < EthHdrLen) want.verdict = VerdictBad;
    else if (cur_etype == EtherTypeLldp) want.verdict = VerdictLldp;
    else if (cur_etype != EtherTypeIpv4 || len < MinIpFrame || cur_ihl < MinIhl) begin
      want.verdict = VerdictBad;
    end else begin
      icmp_type = cur_l4word[31:24];
      has_l4 = 1'b1;
      case (cur_proto)
        ProtoIcmp: need = IcmpNeed;
        ProtoTcp:  need = TcpNeed;
        ProtoUdp:  need = UdpNeed;
        default: begin
          need = 0;
          has_l4 = 1'b0;
        end
      endcase
      if (has_l4 && len < cur_l4start + need) want.verdict = VerdictBad;
      else if (cur_proto == ProtoIcmp &&
               ((cur_src == wl_peer_a && cur_dst == wl_peer_b && icmp_type == IcmpEchoRequest) ||
                (cur_src == wl_peer_b && cur_dst == wl_peer_a && icmp_type == IcmpEchoReply) ||
                cur_src == wl_exempt || cur_dst == wl_exempt)) begin
        want.verdict = VerdictWhitelist;
      end else begin
        want.verdict  = VerdictParsed;
        want.src_addr = cur_src;
        want.dst_addr = cur_dst;
        want.protocol = cur_proto;
        if (cur_proto == ProtoTcp || cur_proto == ProtoUdp) begin
          want.l4_sport = cur_l4word[31:16];
          want.l4_dport = cur_l4word[15:0];
        end
      end
    end
    clear_frame();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  task automatic check_key(input key_t got);
    key_t want;
    if (flow_keys_due.size() == 0) begin
      report_mismatch("key with no frame pending, verdict", got.verdict, 0);
    end else begin
      want = flow_keys_due.pop_front();
      if (got.verdict !== want.verdict) report_mismatch("verdict", got.verdict, want.verdict);
      if (got.src_addr !== want.src_addr) report_mismatch("src_addr", got.src_addr, want.src_addr);
      if (got.dst_addr !== want.dst_addr) report_mismatch("dst_addr", got.dst_addr, want.dst_addr);
      if (got.protocol !== want.protocol) report_mismatch("protocol", got.protocol, want.protocol);
      if (got.l4_sport !== want.l4_sport) report_mismatch("l4_sport", got.l4_sport, want.l4_sport);
      if (got.l4_dport !== want.l4_dport) report_mismatch("l4_dport", got.l4_dport, want.l4_dport);
      if (got.frame_length !== want.frame_length) begin
        report_mismatch("frame_length", got.frame_length, want.frame_length);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_if.valid && frame_if.ready) begin
        if (predict_byte(frame_if.payload, next_key)) flow_keys_due.push_back(next_key);
      end
      if (!frame_if.valid || frame_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          frame_if.payload <= pending_bytes.pop_front();
          frame_if.valid <= 1'b1;
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (key_if.valid && key_if.ready) check_key(key_if.payload);
      if (holds_served != holds_requested) begin
        hold_left = HoldCycles;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        key_if.ready <= 1'b0;
      end else begin
        key_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void queue_frame(input logic [15:0] etype, input int unsigned ihl,
                                      input int unsigned proto, input logic [31:0] src,
                                      input logic [31:0] dst, input int unsigned l4_first,
                                      input int unsigned len);
    logic [7:0]  body[$];
    frame_t      item;
    int unsigned l4_at;
    l4_at = EthHdrLen + 4 * ihl;
    repeat ((len > 80) ? len : 80) body.push_back(8'($urandom));
    body[PosEtherHi] = etype[15:8];
    body[PosEtherLo] = etype[7:0];
    body[PosIhl]     = {body[PosIhl][7:4], 4'(ihl)};
    body[PosProto]   = 8'(proto);
    for (int i = 0; i < 4; i++) begin
      body[PosSrcFirst + i] = src[31 - 8 * i -: 8];
      body[PosDstFirst + i] = dst[31 - 8 * i -: 8];
    end
    if (ihl >= MinIhl) body[l4_at] = 8'(l4_first);
    while (body.size() > len) void'(body.pop_back());
    foreach (body[i]) begin
      item.frame_byte   = body[i];
      item.end_of_frame = (i == body.size() - 1);
      pending_bytes.push_back(item);
    end
  endfunction

  function automatic logic [31:0] any_addr();
    case ($urandom_range(3))
      0:       return wl_peer_a;
      1:       return wl_peer_b;
      2:       return wl_exempt;
      default: return 32'($urandom);
    endcase
  endfunction

  // Mostly well-formed IPv4 frames near their length limits, with some broken ones.
  function automatic int unsigned queue_random_frame();
    int unsigned pick;
    int unsigned ihl;
    int unsigned need;
    int unsigned len;
    logic [7:0]  proto;
    logic [7:0]  l4_first;
    pick = $urandom_range(99);
    ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : MinIhl;
    case ($urandom_range(4))
      0, 3:    proto = ProtoIcmp;
      1:       proto = ProtoTcp;
      2:       proto = ProtoUdp;
      default: proto = 8'($urandom);
    endcase
    case (proto)
      ProtoIcmp: need = IcmpNeed;
      ProtoTcp:  need = TcpNeed;
      ProtoUdp:  need = UdpNeed;
      default:   need = 0;
    endcase
    case ($urandom_range(2))
      0:       l4_first = IcmpEchoRequest;
      1:       l4_first = IcmpEchoReply;
      default: l4_first = 8'($urandom);
    endcase
    if ($urandom_range(4) == 0) len = EthHdrLen + 4 * ihl + need - 1 - $urandom_range(2);
    else len = EthHdrLen + 4 * ihl + need + $urandom_range(12);
    if (pick < 72) begin
      queue_frame(EtherTypeIpv4, 4'(ihl), proto, any_addr(), any_addr(), l4_first, len);
    end else if (pick < 78) begin
      len = $urandom_range(70, MinIpFrame);
      queue_frame(EtherTypeIpv4, 4'($urandom_range(MinIhl - 1)), proto, any_addr(), any_addr(),
                  l4_first, len);
    end else if (pick < 85) begin
      len = $urandom_range(80, EthHdrLen);
      queue_frame(EtherTypeLldp, 4'(ihl), proto, any_addr(), any_addr(), l4_first, len);
    end else if (pick < 92) begin
      len = $urandom_range(80, EthHdrLen);
      queue_frame(16'($urandom), 4'(ihl), proto, any_addr(), any_addr(), l4_first, len);
    end else if (pick < 96) begin
      len = $urandom_range(EthHdrLen - 1, 1);
      queue_frame(16'($urandom), 4'(ihl), proto, any_addr(), any_addr(), l4_first, len);
    end else begin
      len = $urandom_range(MinIpFrame - 1, EthHdrLen);
      queue_frame(EtherTypeIpv4, 4'(ihl), proto, any_addr(), any_addr(), l4_first, len);
    end
    return len;
  endfunction

  function automatic void queue_random_frames(input int unsigned min_bytes,
                                              input int unsigned min_frames);
    int unsigned bytes_done;
    int unsigned frames_done;
    bytes_done = 0;
    frames_done = 0;
    while (bytes_done < min_bytes || frames_done < min_frames) begin
      bytes_done += queue_random_frame();
      frames_done++;
    end
  endfunction

  task automatic drain();
    while (pending_bytes.size() != 0 || frame_if.valid || flow_keys_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input cfg_data_t data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgPeerA:  wl_peer_a = data;
      CfgPeerB:  wl_peer_b = data;
      CfgExempt: wl_exempt = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_data_t peer_a, input cfg_data_t peer_b,
                              input cfg_data_t exempt);
    drain();
    write_reg(CfgPeerA, peer_a);
    write_reg(CfgPeerB, peer_b);
    write_reg(CfgExempt, exempt);
  endtask

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] shared_peer;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgPeerA;
    cfg_wdata        = '0;
    frame_if.valid   = 1'b0;
    frame_if.payload = '0;
    key_if.ready     = 1'b0;
    wl_peer_a        = PeerAReset;
    wl_peer_b        = PeerBReset;
    wl_exempt        = ExemptReset;
    clear_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 62;
    queue_frame(EtherTypeIpv4, 5, ProtoUdp, 0, 0, 0, 1);
    queue_frame(EtherTypeIpv4, 5, ProtoUdp, 0, 0, 0, EthHdrLen - 1);
    queue_frame(EtherTypeLldp, 5, ProtoUdp, 0, 0, 0, EthHdrLen);
    queue_frame(EtherTypeLldp, 5, ProtoTcp, PeerAReset, PeerBReset, 0, 40);
    queue_frame(16'h86DD, 5, ProtoTcp, 32'($urandom), 32'($urandom), 0, 40);
    queue_frame(16'h0000, 5, ProtoTcp, '0, '0, 8'h00, 40);
    queue_frame(16'hFFFF, 15, 8'hFF, '1, '1, 8'hFF, 40);
    queue_frame(EtherTypeIpv4, 5, ProtoTcp, 0, 0, 0, EthHdrLen);
    queue_frame(EtherTypeIpv4, 5, ProtoTcp, 0, 0, 0, MinIpFrame - 1);
    queue_frame(EtherTypeIpv4, 4, ProtoUdp, 32'($urandom), 32'($urandom), 0, 40);
    queue_frame(EtherTypeIpv4, 0, ProtoIcmp, PeerAReset, PeerBReset, IcmpEchoRequest, 40);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, PeerAReset, PeerBReset, IcmpEchoRequest, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, PeerBReset, PeerAReset, IcmpEchoReply, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, PeerAReset, PeerBReset, IcmpEchoReply, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, PeerBReset, PeerAReset, IcmpEchoRequest, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, ExemptReset, 32'h0A000001, 8'd3, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, 32'hFFFFFFFF, ExemptReset, 8'd13, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoIcmp, PeerAReset, PeerBReset, IcmpEchoRequest, 41);
    queue_frame(EtherTypeIpv4, 5, ProtoTcp, 32'($urandom), 32'($urandom), 0, 54);
    queue_frame(EtherTypeIpv4, 5, ProtoTcp, 32'($urandom), 32'($urandom), 0, 53);
    queue_frame(EtherTypeIpv4, 5, ProtoUdp, 32'($urandom), 32'($urandom), 0, 42);
    queue_frame(EtherTypeIpv4, 5, ProtoUdp, 32'($urandom), 32'($urandom), 0, 41);
    queue_frame(EtherTypeIpv4, 5, 8'd47, 32'($urandom), 32'($urandom), 0, MinIpFrame);
    queue_frame(EtherTypeIpv4, 15, ProtoUdp, 32'($urandom), 32'($urandom), 0, 82);
    queue_frame(EtherTypeIpv4, 15, ProtoUdp, 32'($urandom), 32'($urandom), 0, 81);
    queue_frame(EtherTypeIpv4, 6, ProtoTcp, 32'($urandom), 32'($urandom), 0, 58);
    queue_frame(EtherTypeIpv4, 15, 8'd47, 32'($urandom), 32'($urandom), 0, 40);
    queue_random_frames(40, 1);

    apply_config(32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom));
    queue_random_frames(40, 1);

    drain();
    send_idle_pct = 62;
    recv_idle_pct = 30;
    apply_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    queue_random_frames(40, 1);

    shared_peer = 32'($urandom);
    apply_config(shared_peer, shared_peer, 32'($urandom));
    queue_random_frames(40, 1);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(32'($urandom), 32'($urandom), 32'hFFFF_FFFF);
    holds_requested++;
    repeat (12) queue_frame(16'($urandom), 5, 0, 0, 0, 0, $urandom_range(EthHdrLen - 1, 1));
    queue_random_frames(40, 1);
    drain();
    queue_random_frames(40, 1);
    drain();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pfkp_pkg.sv
rtl/pfkp_stream_if.sv
rtl/pfkp_front.sv
rtl/pfkp_queue.sv
rtl/pfkp_back.sv
rtl/packet_flow_key_parser.sv
rtl/pfkp_checker.sv
tb/sv/tb_packet_flow_key_parser.sv
